// ----- hw/rtl/rtp_l24_audio_packetizer_macros.svh -----
// Assertion macros for the RTP L24 packetizer
`ifndef RTP_L24_AUDIO_PACKETIZER_MACROS_SVH
`define RTP_L24_AUDIO_PACKETIZER_MACROS_SVH
`ifndef SYNTHESIS
`define RTPL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RTPL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RTPL_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RTPL_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/rtpl_pkg.sv -----
package rtpl_pkg;
   localparam int FRAMES_PER_PACKET_DEF = 48;
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int HDR_BYTES = 12;
   localparam logic [3:0] DEFAULT_CHANNELS = 4'd2;
   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [6:0] PT_RESET = 7'd96;
   localparam logic [31:0] SSRC_RESET = 32'h1122_3344;
   localparam logic [1:0] REG_CHANNELS = 2'd0;
   localparam logic [1:0] REG_PT = 2'd1;
   localparam logic [1:0] REG_SSRC = 2'd2;
   localparam logic [1:0] REG_SEQ = 2'd3;
   localparam logic [31:0] SCALE_F32 = 32'h4AFF_FFFE; // 8388607.0f
endpackage

// ----- hw/rtl/rtpl_lane.sv -----
// One channel: clamp, multiply by 8388607 (single precision, RNE), truncate.
module rtpl_lane (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] sample,
   output logic [23:0] word
);
   logic        sgn_ff, zero_ff, full_ff;
   logic [46:0] prod_ff;
   logic [7:0]  exp_ff;
   logic        sgn_in, zero_in, full_in;
   logic [46:0] prod_in;
   logic [7:0]  e;
   logic [22:0] m;
   logic [23:0] mag;
   logic [23:0] mant;
   logic [7:0]  sh;
   logic [24:0] r;
   logic        g, st;

   assign e = sample[30:23];
   assign m = sample[22:0];

   always_comb begin
      sgn_in  = sample[31];
      zero_in = (e == 8'hFF && m != 23'd0) || (e < 8'd103);
      full_in = (e >= 8'd127);
      prod_in = {23'd0, 1'b1, m} * {24'd0, 23'h7F_FFFF};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sgn_ff  <= sgn_in;
         zero_ff <= zero_in;
         full_ff <= full_in;
         prod_ff <= prod_in;
         exp_ff  <= e;
      end
   end

   // prod = 1.m * (2^23-1) in units of 2^-23, 46 or 47 significant bits;
   // rounded to 24 bits, then value = r * 2^-sh, truncated.
   always_comb begin
      if (prod_ff[46]) begin
         mant = prod_ff[46:23];
         g = prod_ff[22];
         st = |prod_ff[21:0];
         sh = 8'd127 - exp_ff;
      end else begin
         mant = prod_ff[45:22];
         g = prod_ff[21];
         st = |prod_ff[20:0];
         sh = 8'd128 - exp_ff;
      end
      r = {1'b0, mant} + {24'd0, g & (st | mant[0])};
      mag = 24'(r >> sh);
      if (zero_ff) word = 24'd0;
      else if (full_ff) word = sgn_ff ? 24'h80_0001 : 24'h7F_FFFF;
      else word = sgn_ff ? (24'd0 - mag) : mag;
   end
endmodule

// ----- hw/rtl/rtpl_merge.sv -----
`include "rtp_l24_audio_packetizer_macros.svh"
// Byte serializer: header (when hdr is set) then lane words, one byte per beat.
module rtpl_merge #(
   parameter int MAX_CHANNELS = rtpl_pkg::MAX_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic        hdr,
   input  logic        last_pkt,
   input  logic [3:0]  nch,
   input  logic [95:0] hdr_bytes,
   input  logic [24*MAX_CHANNELS-1:0] words,
   output logic        busy,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_item,
   output logic        rsp_last_of_packet
);
   localparam int TOT = rtpl_pkg::HDR_BYTES + 3 * MAX_CHANNELS;
   localparam int CW = $clog2(TOT + 1);
   logic [8*TOT-1:0] buf_ff, buf_in;
   logic [CW-1:0]    left_ff, left_in;
   logic             pkt_ff, pkt_in;
   logic [CW-1:0]    n;

   always_comb begin
      n = CW'(3 * nch) + (hdr ? CW'(rtpl_pkg::HDR_BYTES) : CW'(0));
      buf_in = buf_ff;
      left_in = left_ff;
      pkt_in = pkt_ff;
      if (load) begin
         buf_in = '0;
         for (int c = 0; c < MAX_CHANNELS; c++)
            buf_in[8*TOT-1-8*rtpl_pkg::HDR_BYTES-24*c -: 24] = words[24*c +: 24];
         if (hdr) buf_in[8*TOT-1 -: 96] = hdr_bytes;
         else buf_in = buf_in << (8 * rtpl_pkg::HDR_BYTES);
         left_in = n;
         pkt_in = last_pkt;
      end else if (rsp_valid && !rsp_stall) begin
         buf_in = buf_ff << 8;
         left_in = left_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         pkt_ff <= 1'b0;
      end else begin
         left_ff <= left_in;
         pkt_ff <= pkt_in;
      end
      buf_ff <= buf_in;
   end

   assign rsp_valid = (left_ff != '0);
   assign busy = (left_ff > CW'(1)) || (rsp_valid && rsp_stall);
   assign rsp_out_byte = buf_ff[8*TOT-1 -: 8];
   assign rsp_last_of_item = (left_ff == CW'(1));
   assign rsp_last_of_packet = rsp_last_of_item && pkt_ff;

   `RTPL_ASSERT_IMP(a_noload_busy, clock, reset, load, !busy, "load while busy")
   `RTPL_ASSERT_NXT(a_hold, clock, reset, rsp_valid && rsp_stall, left_ff == $past(left_ff), "count moved")
   `RTPL_ASSERT_IMP(a_pkt_last, clock, reset, rsp_last_of_packet, rsp_last_of_item, "flag order")
endmodule

// ----- hw/rtl/rtp_l24_audio_packetizer.sv -----
`include "rtp_l24_audio_packetizer_macros.svh"
// An accepted frame is registered in the lanes, then loaded into the merge
// buffer, which drives its first byte. One byte per cycle while rsp_stall is
// low; a frame is 3*channels bytes (+12 on a packet's first), plus a load step.
// Next frame is taken while the current frame's last byte is out.
// Synchronous reset: CSRs to defaults, sequence 0, position 0, no bytes pending.
module rtp_l24_audio_packetizer #(
   parameter int FRAMES_PER_PACKET = rtpl_pkg::FRAMES_PER_PACKET_DEF,
   parameter int MAX_CHANNELS = rtpl_pkg::MAX_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_media_timestamp,
   input  logic [31:0] req_sample_0,
   input  logic [31:0] req_sample_1,
   input  logic [31:0] req_sample_2,
   input  logic [31:0] req_sample_3,
   input  logic [31:0] req_sample_4,
   input  logic [31:0] req_sample_5,
   input  logic [31:0] req_sample_6,
   input  logic [31:0] req_sample_7,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_item,
   output logic        rsp_last_of_packet
);
   localparam int PW = $clog2(FRAMES_PER_PACKET + 1);
   logic [3:0]  nch_ff;
   logic [6:0]  pt_ff;
   logic [31:0] ssrc_ff;
   logic [15:0] seq_ff, seq_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic        v1_ff, hdr_ff, lastp_ff;
   logic [3:0]  n1_ff;
   logic [95:0] hb_ff;
   logic        busy, acc, lastf;
   logic [3:0]  nch_eff;
   logic [31:0] smp [8];
   logic [24*MAX_CHANNELS-1:0] words;

   assign smp[0] = req_sample_0; assign smp[1] = req_sample_1;
   assign smp[2] = req_sample_2; assign smp[3] = req_sample_3;
   assign smp[4] = req_sample_4; assign smp[5] = req_sample_5;
   assign smp[6] = req_sample_6; assign smp[7] = req_sample_7;

   assign req_stall = reset || busy || v1_ff;
   assign acc = req_valid && !req_stall;
   assign nch_eff = (nch_ff == 4'd0 || nch_ff > 4'(MAX_CHANNELS))
      ? rtpl_pkg::DEFAULT_CHANNELS : nch_ff;
   assign lastf = (pos_ff + PW'(1) >= PW'(FRAMES_PER_PACKET));

   always_comb begin
      seq_in = seq_ff;
      pos_in = pos_ff;
      if (acc) begin
         pos_in = lastf ? '0 : pos_ff + PW'(1);
         if (lastf) seq_in = seq_ff + 16'd1;
      end
      if (csr_write && csr_index == rtpl_pkg::REG_SEQ) seq_in = csr_data[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nch_ff <= rtpl_pkg::DEFAULT_CHANNELS;
         pt_ff <= rtpl_pkg::PT_RESET;
         ssrc_ff <= rtpl_pkg::SSRC_RESET;
         seq_ff <= '0;
         pos_ff <= '0;
         v1_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               rtpl_pkg::REG_CHANNELS: nch_ff <= csr_data[3:0];
               rtpl_pkg::REG_PT:       pt_ff <= csr_data[6:0];
               rtpl_pkg::REG_SSRC:     ssrc_ff <= csr_data;
               default: ;
            endcase
         end
         seq_ff <= seq_in;
         pos_ff <= pos_in;
         v1_ff <= acc;
      end
      if (acc) begin
         hdr_ff <= (pos_ff == '0);
         lastp_ff <= lastf;
         n1_ff <= nch_eff;
         hb_ff <= {rtpl_pkg::RTP_VERSION_BYTE, 1'b0, pt_ff, seq_ff,
                   req_media_timestamp, ssrc_ff};
      end
   end

   for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
      rtpl_lane u_lane (
         .clock(clock), .en(acc), .sample(smp[c]), .word(words[24*c +: 24])
      );
   end

   rtpl_merge #(.MAX_CHANNELS(MAX_CHANNELS)) u_merge (
      .clock(clock), .reset(reset), .load(v1_ff), .hdr(hdr_ff),
      .last_pkt(lastp_ff), .nch(n1_ff), .hdr_bytes(hb_ff), .words(words),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte), .rsp_last_of_item(rsp_last_of_item),
      .rsp_last_of_packet(rsp_last_of_packet)
   );

   `RTPL_ASSERT_NXT(a_one_load, clock, reset, acc, !acc, "double accept")
   `RTPL_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, pos_ff < PW'(FRAMES_PER_PACKET), "pos range")
   `RTPL_ASSERT_NXT(a_seq_step, clock, reset, acc && lastf && !csr_write, seq_ff == $past(seq_ff) + 16'd1, "seq step")
endmodule
